/* sv/segment_plane_intersection_assert.svh */
`ifndef SEGMENT_PLANE_INTERSECTION_ASSERT_SVH
`define SEGMENT_PLANE_INTERSECTION_ASSERT_SVH

// same-cycle implication, off during reset
`define SPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset as well
`define SPI_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/spi_pkg.sv */
`default_nettype none

package spi_pkg;

    localparam int COORD_W   = 32;
    localparam int QUOT_W    = 34;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEVEL        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        HIT_PARALLEL = 2'd0,
        HIT_OUTSIDE  = 2'd1,
        HIT_WITHIN   = 2'd2
    } hit_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } spi_in_t;

    typedef struct packed {
        logic        [1:0]         hit_status;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
        logic signed [COORD_W-1:0] cross_z;
    } spi_out_t;

    typedef struct packed {
        logic parallel;
        logic on_segment;
    } spi_flags_t;

endpackage

`default_nettype wire

/* sv/segment_plane_intersection.sv */
// Segment against plane intersection, signed fixed point.
// Input channel s_valid/s_ready/s_item carries two 3D points; result channel
// m_valid/m_ready/m_item returns the crossing point of the line through them
// with the plane L*x + L*y + z = L, and a status: parallel, outside or within.
// Configuration: cfg_we with cfg_index 0 writes plane_level (L), index 1
// writes parallel_threshold; write only while no item is in flight.
// The item passes 47 register stages: 5 of denominator/numerator work, 41
// per coordinate lane (34 of them a pipelined restoring divider, one quotient
// bit per stage) and the output register. Throughput is one item per cycle
// while the output is not stalled; the three coordinate lanes run side by
// side.
// All stages share one advance enable. When m_valid is high and m_ready low
// the whole pipeline holds and s_ready drops; no item is lost or repeated.
// Bubbles advance only while the output moves or is empty.
// Reset (aresetn low at a clock edge) clears all valid bits and sets
// plane_level to 1.0 and parallel_threshold to zero.
`default_nettype none

module segment_plane_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire spi_pkg::spi_in_t                    s_item,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output spi_pkg::spi_out_t                        m_item,
    input  wire logic                                cfg_we,
    input  wire logic [spi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [spi_pkg::CFG_W-1:0]           cfg_wdata
);
    import spi_pkg::*;

    localparam int PL_W      = 2 * COORD_W + 2;
    localparam int SH_W      = COORD_W + 1 + FRAC_BITS;
    localparam int DW        = ((PL_W > SH_W) ? PL_W : SH_W) + 1;
    localparam int MW        = DW - 1;
    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = QUOT_W + 7;
    localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

    logic signed [CFG_W-1:0] plane_level_reg;
    logic        [CFG_W-1:0] parallel_threshold_reg;
    logic                    ce;
    logic                    vld_reg [PIPE_LAT];
    logic                    m_valid_reg;
    spi_out_t                m_item_reg;
    spi_out_t                m_item_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_level_reg        <= 32'sd65536;
            parallel_threshold_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PLANE_LEVEL:        plane_level_reg        <= cfg_wdata;
                REG_PARALLEL_THRESHOLD: parallel_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advances when the output register is free or drained
    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    logic        [MW-1:0]      numm, detm;
    logic                      numneg;
    spi_flags_t                flags;
    logic signed [COORD_W-1:0] c1 [3];
    logic signed [COORD_W:0]   dc [3];
    logic signed [COORD_W-1:0] coord [3];

    spi_front #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_front (
        .aclk               (aclk),
        .ce                 (ce),
        .item               (s_item),
        .plane_level        (plane_level_reg),
        .parallel_threshold (parallel_threshold_reg),
        .numm               (numm),
        .numneg             (numneg),
        .detm               (detm),
        .flags              (flags),
        .c1                 (c1),
        .dc                 (dc)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        spi_lane #(
            .MW (MW)
        ) u_lane (
            .aclk   (aclk),
            .ce     (ce),
            .numm   (numm),
            .numneg (numneg),
            .detm   (detm),
            .c1     (c1[k]),
            .dc     (dc[k]),
            .coord  (coord[k])
        );
    end

    // status flags ride alongside the lanes
    spi_flags_t flags_reg [LANE_LAT];

    always_ff @(posedge aclk) begin
        if (ce) begin
            flags_reg[0] <= flags;
            for (int i = 1; i < LANE_LAT; i++) begin
                flags_reg[i] <= flags_reg[i-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // result assembly, zero point when parallel
    always_comb begin
        if (flags_reg[LANE_LAT-1].parallel) begin
            m_item_next.hit_status = HIT_PARALLEL;
            m_item_next.cross_x    = '0;
            m_item_next.cross_y    = '0;
            m_item_next.cross_z    = '0;
        end else begin
            m_item_next.hit_status = flags_reg[LANE_LAT-1].on_segment ? HIT_WITHIN : HIT_OUTSIDE;
            m_item_next.cross_x    = coord[0];
            m_item_next.cross_y    = coord[1];
            m_item_next.cross_z    = coord[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

/* sv/spi_front.sv */
`default_nettype none

module spi_front #(
    parameter int FRAC_BITS = 16,
    parameter int DW        = 67
) (
    input  wire logic                              aclk,
    input  wire logic                              ce,
    input  wire spi_pkg::spi_in_t                  item,
    input  wire logic signed [spi_pkg::CFG_W-1:0]  plane_level,
    input  wire logic        [spi_pkg::CFG_W-1:0]  parallel_threshold,
    output logic             [DW-2:0]              numm,
    output logic                                   numneg,
    output logic             [DW-2:0]              detm,
    output spi_pkg::spi_flags_t                    flags,
    output logic signed [spi_pkg::COORD_W-1:0]     c1 [3],
    output logic signed [spi_pkg::COORD_W:0]       dc [3]
);
    import spi_pkg::*;

    localparam int MW = DW - 1;
    localparam int PW = COORD_W + COORD_W + 2;
    localparam logic signed [COORD_W+1:0] ONE = (COORD_W+2)'(1) << FRAC_BITS;

    // stage 1 registers
    logic signed [COORD_W-1:0] c1_s1_reg [3];
    logic signed [COORD_W:0]   dc_s1_reg [3];
    logic signed [COORD_W+1:0] dxy_s1_reg;
    logic signed [COORD_W+1:0] a_s1_reg;
    // stage 2
    logic signed [COORD_W-1:0] c1_s2_reg [3];
    logic signed [COORD_W:0]   dc_s2_reg [3];
    logic signed [PW-1:0]      pl1_s2_reg;
    logic signed [PW-1:0]      pl2_s2_reg;
    // stage 3
    logic signed [COORD_W-1:0] c1_s3_reg [3];
    logic signed [COORD_W:0]   dc_s3_reg [3];
    logic signed [DW-1:0]      det_s3_reg;
    logic signed [DW-1:0]      num_s3_reg;
    // stage 4
    logic signed [COORD_W-1:0] c1_s4_reg [3];
    logic signed [COORD_W:0]   dc_s4_reg [3];
    logic signed [DW-1:0]      numf_s4_reg;
    logic        [MW-1:0]      detm_s4_reg;
    spi_flags_t                flags_s4_reg;
    // stage 5
    logic signed [COORD_W-1:0] c1_s5_reg [3];
    logic signed [COORD_W:0]   dc_s5_reg [3];
    logic        [MW-1:0]      numm_s5_reg;
    logic                      numneg_s5_reg;
    logic        [MW-1:0]      detm_s5_reg;
    spi_flags_t                flags_s5_reg;

    logic signed [COORD_W:0]   dx_next, dy_next, dz_next;
    logic signed [DW-1:0]      dzs, z1s, det_neg, num_neg, numf_next;
    logic        [MW-1:0]      detm_next, thr_ext;
    spi_flags_t                flags_next;
    logic signed [DW-1:0]      numf_abs;

    // differences of the two points
    always_comb begin
        dx_next = {item.second_x[COORD_W-1], item.second_x}
                - {item.first_x[COORD_W-1], item.first_x};
        dy_next = {item.second_y[COORD_W-1], item.second_y}
                - {item.first_y[COORD_W-1], item.first_y};
        dz_next = {item.second_z[COORD_W-1], item.second_z}
                - {item.first_z[COORD_W-1], item.first_z};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c1_s1_reg[0] <= item.first_x;
            c1_s1_reg[1] <= item.first_y;
            c1_s1_reg[2] <= item.first_z;
            dc_s1_reg[0] <= dx_next;
            dc_s1_reg[1] <= dy_next;
            dc_s1_reg[2] <= dz_next;
            dxy_s1_reg   <= (COORD_W+2)'(dx_next) + (COORD_W+2)'(dy_next);
            a_s1_reg     <= ONE - (COORD_W+2)'(item.first_x) - (COORD_W+2)'(item.first_y);
        end
    end

    // plane products
    always_ff @(posedge aclk) begin
        if (ce) begin
            c1_s2_reg  <= c1_s1_reg;
            dc_s2_reg  <= dc_s1_reg;
            pl1_s2_reg <= plane_level * dxy_s1_reg;
            pl2_s2_reg <= plane_level * a_s1_reg;
        end
    end

    // denominator and numerator at scale 2*FRAC_BITS
    always_comb begin
        dzs = DW'(dc_s2_reg[2]) <<< FRAC_BITS;
        z1s = DW'(c1_s2_reg[2]) <<< FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c1_s3_reg  <= c1_s2_reg;
            dc_s3_reg  <= dc_s2_reg;
            det_s3_reg <= DW'(pl1_s2_reg) + dzs;
            num_s3_reg <= DW'(pl2_s2_reg) - z1s;
        end
    end

    // make the denominator positive, parallel and betweenness tests
    always_comb begin
        det_neg   = -det_s3_reg;
        num_neg   = -num_s3_reg;
        detm_next = det_s3_reg[DW-1] ? det_neg[MW-1:0] : det_s3_reg[MW-1:0];
        numf_next = det_s3_reg[DW-1] ? num_neg : num_s3_reg;
        thr_ext   = {{(MW-CFG_W-FRAC_BITS){1'b0}}, parallel_threshold, {FRAC_BITS{1'b0}}};
        flags_next.parallel   = (detm_next <= thr_ext);
        flags_next.on_segment = !numf_next[DW-1] && (numf_next <= $signed({1'b0, detm_next}));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c1_s4_reg    <= c1_s3_reg;
            dc_s4_reg    <= dc_s3_reg;
            numf_s4_reg  <= numf_next;
            detm_s4_reg  <= detm_next;
            flags_s4_reg <= flags_next;
        end
    end

    // numerator magnitude and sign
    assign numf_abs = numf_s4_reg[DW-1] ? -numf_s4_reg : numf_s4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            c1_s5_reg     <= c1_s4_reg;
            dc_s5_reg     <= dc_s4_reg;
            numm_s5_reg   <= numf_abs[MW-1:0];
            numneg_s5_reg <= numf_s4_reg[DW-1];
            detm_s5_reg   <= detm_s4_reg;
            flags_s5_reg  <= flags_s4_reg;
        end
    end

    assign numm   = numm_s5_reg;
    assign numneg = numneg_s5_reg;
    assign detm   = detm_s5_reg;
    assign flags  = flags_s5_reg;
    assign c1     = c1_s5_reg;
    assign dc     = dc_s5_reg;

endmodule

`default_nettype wire

/* sv/spi_lane.sv */
`default_nettype none

module spi_lane #(
    parameter int MW = 66
) (
    input  wire logic                               aclk,
    input  wire logic                               ce,
    input  wire logic        [MW-1:0]               numm,
    input  wire logic                               numneg,
    input  wire logic        [MW-1:0]               detm,
    input  wire logic signed [spi_pkg::COORD_W-1:0] c1,
    input  wire logic signed [spi_pkg::COORD_W:0]   dc,
    output logic signed      [spi_pkg::COORD_W-1:0] coord
);
    import spi_pkg::*;

    localparam int QW   = QUOT_W;
    localparam int DCW  = COORD_W + 1;
    localparam int LOW  = QW;
    localparam int HIW  = MW - LOW;
    localparam int PW   = MW + DCW;
    localparam int SW   = COORD_W + 4;
    localparam logic [QW-1:0] QLIM = QW'(1) << (QW - 1);

    // stage 1: magnitude of the difference, product sign
    logic [MW-1:0]             numm_l1_reg, detm_l1_reg;
    logic [DCW-1:0]            dcm_l1_reg;
    logic                      neg_l1_reg;
    logic signed [COORD_W-1:0] c1_l1_reg;
    logic [DCW-1:0]            dc_abs;

    assign dc_abs = dc[DCW-1] ? DCW'(-dc) : DCW'(dc);

    always_ff @(posedge aclk) begin
        if (ce) begin
            numm_l1_reg <= numm;
            detm_l1_reg <= detm;
            dcm_l1_reg  <= dc_abs;
            neg_l1_reg  <= numneg ^ dc[DCW-1];
            c1_l1_reg   <= c1;
        end
    end

    // stage 2: two partial products
    logic [LOW+DCW-1:0]        plo_l2_reg;
    logic [HIW+DCW-1:0]        phi_l2_reg;
    logic [MW-1:0]             detm_l2_reg;
    logic                      neg_l2_reg;
    logic signed [COORD_W-1:0] c1_l2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            plo_l2_reg  <= numm_l1_reg[LOW-1:0] * dcm_l1_reg;
            phi_l2_reg  <= numm_l1_reg[MW-1:LOW] * dcm_l1_reg;
            detm_l2_reg <= detm_l1_reg;
            neg_l2_reg  <= neg_l1_reg;
            c1_l2_reg   <= c1_l1_reg;
        end
    end

    // stage 3: combine partial products
    logic [PW-1:0]             pm_l3_reg;
    logic [MW-1:0]             detm_l3_reg;
    logic                      neg_l3_reg;
    logic signed [COORD_W-1:0] c1_l3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            pm_l3_reg   <= (PW'(phi_l2_reg) << LOW) + PW'(plo_l2_reg);
            detm_l3_reg <= detm_l2_reg;
            neg_l3_reg  <= neg_l2_reg;
            c1_l3_reg   <= c1_l2_reg;
        end
    end

    // stage 4: add half the divisor for round to nearest
    logic [PW:0]               nn_l4_reg;
    logic [MW-1:0]             detm_l4_reg;
    logic                      neg_l4_reg;
    logic signed [COORD_W-1:0] c1_l4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            nn_l4_reg   <= (PW+1)'(pm_l3_reg) + (PW+1)'(detm_l3_reg >> 1);
            detm_l4_reg <= detm_l3_reg;
            neg_l4_reg  <= neg_l3_reg;
            c1_l4_reg   <= c1_l3_reg;
        end
    end

    // divider stages, index 0 is loaded by the overflow check
    logic [MW-1:0]             rem_reg  [0:QW];
    logic [QW-1:0]             q_reg    [0:QW];
    logic [QW-1:0]             nlo_reg  [0:QW];
    logic [MW-1:0]             dv_reg   [0:QW];
    logic                      neg_reg  [0:QW];
    logic                      ovf_reg  [0:QW];
    logic signed [COORD_W-1:0] c1_reg   [0:QW];
    logic                      ovf_next;

    // quotient beyond QW bits clamps anyway
    assign ovf_next = (nn_l4_reg >= ((PW+1)'(detm_l4_reg) << QW));

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= ovf_next ? '0 : nn_l4_reg[PW:QW];
            q_reg[0]   <= '0;
            nlo_reg[0] <= nn_l4_reg[QW-1:0];
            dv_reg[0]  <= detm_l4_reg;
            neg_reg[0] <= neg_l4_reg;
            ovf_reg[0] <= ovf_next;
            c1_reg[0]  <= c1_l4_reg;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        logic [MW:0]   trial;
        logic [MW:0]   diff;
        logic          ge;
        logic [MW-1:0] rem_next;
        logic [QW-1:0] q_next;

        // one restoring step, one quotient bit
        always_comb begin
            trial    = {rem_reg[g], nlo_reg[g][QW-1-g]};
            diff     = trial - {1'b0, dv_reg[g]};
            ge       = (trial >= {1'b0, dv_reg[g]});
            rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];
            q_next   = q_reg[g];
            q_next[QW-1-g] = ge;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[g+1] <= rem_next;
                q_reg[g+1]   <= q_next;
                nlo_reg[g+1] <= nlo_reg[g];
                dv_reg[g+1]  <= dv_reg[g];
                neg_reg[g+1] <= neg_reg[g];
                ovf_reg[g+1] <= ovf_reg[g];
                c1_reg[g+1]  <= c1_reg[g];
            end
        end
    end

    // clamp the quotient and apply the sign
    logic signed [QW:0]        qs_f1_reg;
    logic signed [COORD_W-1:0] c1_f1_reg;
    logic        [QW-1:0]      qc;

    assign qc = (ovf_reg[QW] || (q_reg[QW] > QLIM)) ? QLIM : q_reg[QW];

    always_ff @(posedge aclk) begin
        if (ce) begin
            qs_f1_reg <= neg_reg[QW] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
            c1_f1_reg <= c1_reg[QW];
        end
    end

    // add to the first point and saturate
    logic signed [SW-1:0]      sum;
    logic signed [COORD_W-1:0] coord_next;
    logic signed [COORD_W-1:0] coord_reg;

    always_comb begin
        sum = SW'(c1_f1_reg) + SW'(qs_f1_reg);
        if (sum[SW-1:COORD_W-1] == '0 || sum[SW-1:COORD_W-1] == '1) begin
            coord_next = sum[COORD_W-1:0];
        end else if (sum[SW-1]) begin
            coord_next = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            coord_next = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

`default_nettype wire

/* sv/spi_checker.sv */
`default_nettype none
`include "segment_plane_intersection_assert.svh"

module spi_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire spi_pkg::spi_in_t               s_item,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire spi_pkg::spi_out_t              m_item,
    input wire logic                           cfg_we,
    input wire logic [spi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [spi_pkg::CFG_W-1:0]      cfg_wdata
);
    import spi_pkg::*;

    // a stalled result holds
    `SPI_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")

    // input side follows the output register
    `SPI_ASSERT_NOW(a_ready_link, 1'b1, s_ready == (!m_valid || m_ready), "s_ready does not track the output stage")

    // parallel result carries the zero point
    `SPI_ASSERT_NOW(a_parallel_zero, m_valid && m_item.hit_status == HIT_PARALLEL, m_item.cross_x == 0 && m_item.cross_y == 0 && m_item.cross_z == 0, "parallel result has a nonzero point")

    // no result right after reset
    `SPI_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

endmodule

bind segment_plane_intersection spi_checker u_spi_checker (.*);

`default_nettype wire
